FILE: hw/rtl/fcfs_schedule_metrics_core_macros.svh
// Assertion macros for the scheduling-metrics RTL.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef FCFS_SCHEDULE_METRICS_CORE_MACROS_SVH
`define FCFS_SCHEDULE_METRICS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fcfs_sm_pkg.sv
// Package for the scheduling-metrics block: widths, job entry types, chain opcodes
// and controller states. No dependencies.
package fcfs_sm_pkg;

    localparam int DEF_MAX_JOBS = 32;
    localparam int TIME_W       = 16;
    localparam int NUM_W        = 6;
    localparam int RES_W        = 21;
    localparam logic [RES_W-1:0] SAT_RES = {RES_W{1'b1}};

    // One stored job.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bur;
        logic [NUM_W-1:0]  num;
    } t_job_entry;

    // Operation applied by every cell of the chain in a cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE,
        OP_POP
    } t_chain_op;

    // Command broadcast to all cells.
    typedef struct packed {
        t_chain_op         op;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bur;
        logic [NUM_W-1:0]  num;
    } t_cell_cmd;

    // Controller states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

FILE: hw/rtl/fcfs_sm_cell.sv
// One cell of the sorted job chain. Holds a single job and trades it with its
// neighbors under the broadcast command. Depends on fcfs_sm_pkg.
module fcfs_sm_cell
    import fcfs_sm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_cmd  i_cmd,
    input  t_job_entry i_prev,
    input  t_job_entry i_next,
    input  t_job_entry i_head,
    output t_job_entry o_entry
);

    t_job_entry r_entry;
    t_job_entry n_entry;
    t_job_entry w_new;
    logic       w_gt_self;
    logic       w_gt_prev;
    logic       w_is_tail;

    // Comparisons against the job being inserted.
    assign w_gt_self = r_entry.valid && (r_entry.arr > i_cmd.arr);
    assign w_gt_prev = i_prev.valid && (i_prev.arr > i_cmd.arr);
    assign w_is_tail = r_entry.valid && !i_next.valid;

    always_comb begin
        w_new.valid = 1'b1;
        w_new.arr   = i_cmd.arr;
        w_new.bur   = i_cmd.bur;
        w_new.num   = i_cmd.num;
    end

    // Next content of the cell.
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            OP_INSERT: begin
                // Later-arriving jobs move up by one; the new job lands behind
                // every job with an equal or earlier arrival.
                if (w_gt_prev) begin
                    n_entry = i_prev;
                end else if (w_gt_self || (!r_entry.valid && i_prev.valid)) begin
                    n_entry = w_new;
                end
            end
            OP_ROTATE: begin
                if (w_is_tail) begin
                    n_entry = i_head;
                end else if (r_entry.valid) begin
                    n_entry = i_next;
                end
            end
            OP_POP: begin
                n_entry = i_next;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_entry.arr <= n_entry.arr;
        r_entry.bur <= n_entry.bur;
        r_entry.num <= n_entry.num;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: hw/rtl/fcfs_sm_div.sv
// Restoring divider, one quotient bit per cycle, for the mean wait.
// Depends on fcfs_sm_pkg only through the import convention.
module fcfs_sm_div
    import fcfs_sm_pkg::*;
#(
    parameter int DVD_W = 28,
    parameter int DVS_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hw/rtl/fcfs_schedule_metrics_core.sv
// Top level of the first-come-first-served scheduling-metrics block.
// Depends on fcfs_sm_pkg, fcfs_sm_cell, fcfs_sm_div and the assertion macros header.
//
// Usage:
//   The slave stream loads one job per transfer: tdata holds arrival and burst,
//   tlast marks the final job of a batch. Jobs are numbered from 1 in load order
//   and kept in a chain of cells sorted stably by arrival; a job loaded while the
//   chain already holds MAX_JOBS jobs is dropped, but its tlast still counts.
//   After the tlast transfer the block stops taking jobs and makes two passes
//   over the chain: one pass rotates the chain through the head cell to total
//   the waits, then the bit-serial divider forms the mean, then one result per
//   job leaves the master stream in arrival order, at most one per cycle, with
//   tlast on the final result.
//   A stall on the master side holds the current result and pauses emission.
//   Loading of the next batch starts as soon as the last result sits in the
//   output register. Reset empties the chain and returns to loading.
module fcfs_schedule_metrics_core
    import fcfs_sm_pkg::*;
#(
    parameter int MAX_JOBS = DEF_MAX_JOBS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // arrival_time[15:0], burst_time[31:16]
    input  logic         s_axis_tlast,   // last_job
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // job_number[5:0], job_arrival[21:6],
                                         // job_burst[37:22], wait_ticks[58:38],
                                         // turnaround_ticks[79:59], mean_wait[100:80],
                                         // zero fill[103:101]
    output logic         m_axis_tlast    // last_result
);

`include "fcfs_schedule_metrics_core_macros.svh"

    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    localparam int FIN_RAW = TIME_W + $clog2(MAX_JOBS + 2);
    localparam int FIN_W   = (FIN_RAW < RES_W + 1) ? RES_W + 1 : FIN_RAW;
    localparam int SUM_RAW = TIME_W + 2 * $clog2(MAX_JOBS + 1);
    localparam int SUM_W   = (SUM_RAW < RES_W + 1) ? RES_W + 1 : SUM_RAW;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_step;
    logic [CNT_W-1:0]     n_step;
    logic [FIN_W-1:0]     r_finish;
    logic [FIN_W-1:0]     n_finish;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     n_sum;
    logic [RES_W-1:0]     r_mean;
    logic [RES_W-1:0]     n_mean;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 w_load_out;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [SUM_W-1:0]     w_quotient;
    logic                 w_in_xfer;
    t_cell_cmd            w_cmd;
    t_job_entry           w_entry [MAX_JOBS];
    t_job_entry           w_head;
    logic [MAX_JOBS-1:0]  w_valid_vec;
    logic [FIN_W-1:0]     w_start;
    logic [FIN_W-1:0]     w_wait;
    logic [FIN_W:0]       w_turn;
    logic [RES_W-1:0]     w_wait_sat;
    logic [RES_W-1:0]     w_turn_sat;
    logic [NUM_W-1:0]     r_o_num;
    logic [TIME_W-1:0]    r_o_arr;
    logic [TIME_W-1:0]    r_o_bur;
    logic [RES_W-1:0]     r_o_wait;
    logic [RES_W-1:0]     r_o_turn;
    logic [RES_W-1:0]     r_o_mean;
    logic                 r_o_last;

    localparam t_job_entry CHAIN_START = '{valid: 1'b1, arr: '0, bur: '0, num: '0};
    localparam t_job_entry CHAIN_END   = '{valid: 1'b0, arr: '0, bur: '0, num: '0};

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;
    assign w_head    = w_entry[0];

    // Chain of job cells; cell 0 is the head.
    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        t_job_entry w_prev;
        t_job_entry w_next;
        if (g == 0) begin : g_first
            assign w_prev = CHAIN_START;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
        end
        if (g == MAX_JOBS - 1) begin : g_last
            assign w_next = CHAIN_END;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end
        fcfs_sm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_head),
            .o_entry (w_entry[g])
        );
        assign w_valid_vec[g] = w_entry[g].valid;
    end

    // Mean wait divider; it takes the total including the final job's wait.
    fcfs_sm_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Schedule arithmetic on the head job.
    always_comb begin
        w_start    = (FIN_W'(w_head.arr) > r_finish) ? FIN_W'(w_head.arr) : r_finish;
        w_wait     = w_start - FIN_W'(w_head.arr);
        w_turn     = {1'b0, w_wait} + (FIN_W + 1)'(w_head.bur);
        w_wait_sat = (w_wait > FIN_W'(SAT_RES)) ? SAT_RES : w_wait[RES_W-1:0];
        w_turn_sat = (w_turn > (FIN_W + 1)'(SAT_RES)) ? SAT_RES : w_turn[RES_W-1:0];
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, chain commands and bookkeeping.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_finish    = r_finish;
        n_sum       = r_sum;
        n_mean      = r_mean;
        n_out_valid = r_out_valid;
        w_load_out  = 1'b0;
        w_div_start = 1'b0;
        w_cmd.op    = OP_HOLD;
        w_cmd.arr   = s_axis_tdata[15:0];
        w_cmd.bur   = s_axis_tdata[31:16];
        w_cmd.num   = NUM_W'(r_count) + NUM_W'(1);
        s_axis_tready = 1'b0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                if (w_in_xfer) begin
                    if (r_count < CNT_W'(MAX_JOBS)) begin
                        w_cmd.op = OP_INSERT;
                        n_count  = r_count + CNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        n_state  = ST_SUM;
                        n_step   = '0;
                        n_finish = '0;
                        n_sum    = '0;
                    end
                end
            end
            ST_SUM: begin
                // Rotate the chain once around, totaling the waits.
                w_cmd.op = OP_ROTATE;
                n_sum    = r_sum + SUM_W'(w_wait);
                n_finish = w_start + FIN_W'(w_head.bur);
                n_step   = r_step + CNT_W'(1);
                if (r_step == r_count - CNT_W'(1)) begin
                    n_state     = ST_DIV;
                    w_div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_mean   = (w_quotient > SUM_W'(SAT_RES)) ? SAT_RES
                                                              : w_quotient[RES_W-1:0];
                    n_finish = '0;
                    n_count  = '0;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Pop one job into the output register whenever it is free.
                if (!r_out_valid || m_axis_tready) begin
                    w_cmd.op    = OP_POP;
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_finish    = w_start + FIN_W'(w_head.bur);
                    if (!w_entry[1].valid) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Accumulators and output payload.
    always_ff @(posedge i_clk) begin
        r_finish <= n_finish;
        r_sum    <= n_sum;
        r_mean   <= n_mean;
        if (w_load_out) begin
            r_o_num  <= w_head.num;
            r_o_arr  <= w_head.arr;
            r_o_bur  <= w_head.bur;
            r_o_wait <= w_wait_sat;
            r_o_turn <= w_turn_sat;
            r_o_mean <= r_mean;
            r_o_last <= !w_entry[1].valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {3'b000, r_o_mean, r_o_turn, r_o_wait, r_o_bur, r_o_arr, r_o_num};

    // Checks on the controller and the chain.
    `FCFS_ASSERT_IMP(a_chain_count, (r_state != ST_EMIT),
        ($countones(w_valid_vec) == r_count), "chain occupancy differs from job count")
    `FCFS_ASSERT_IMP(a_emit_nonempty, (r_state == ST_EMIT), (w_entry[0].valid),
        "emitting from an empty chain")
    `FCFS_ASSERT_IMP(a_div_nonzero, (r_state == ST_DIV), (r_count != '0),
        "mean taken over zero jobs")
    `FCFS_ASSERT_NXT(a_last_starts, (w_in_xfer && s_axis_tlast), (r_state == ST_SUM),
        "batch end did not start the sum pass")
    `FCFS_ASSERT_IMP(a_out_source, ($rose(m_axis_tvalid)), ($past(r_state) == ST_EMIT),
        "result appeared outside emission")

endmodule
